// ===== hdl/rsi_pkg.sv =====
`timescale 1ns / 1ps

package rsi_pkg;

    // Fraction bits of every coordinate and of the distance
    localparam int FRAC_BITS   = 16;
    // Extra fraction bits applied to the discriminant before the square root
    localparam int SQRT_SHIFT  = 32;
    localparam int DIST_WIDTH  = 32;
    localparam int COLOR_WIDTH = 8;
    localparam int CFG_IDX_W   = 3;

    localparam logic [DIST_WIDTH-1:0] DIST_MAX = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTER_X   = 3'd0,
        CFG_CENTER_Y   = 3'd1,
        CFG_CENTER_Z   = 3'd2,
        CFG_RADIUS     = 3'd3,
        CFG_COLOR_RED  = 3'd4,
        CFG_COLOR_GRN  = 3'd5,
        CFG_COLOR_BLUE = 3'd6
    } t_cfg_idx;

    typedef logic [COLOR_WIDTH-1:0] t_color;
    typedef logic [DIST_WIDTH-1:0]  t_dist;

endpackage

// ===== hdl/rsi_ray_if.sv =====
`timescale 1ns / 1ps

interface rsi_ray_if #(
    parameter int W = 32
);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] origin_x;
    logic signed [W-1:0] origin_y;
    logic signed [W-1:0] origin_z;
    logic signed [W-1:0] dir_x;
    logic signed [W-1:0] dir_y;
    logic signed [W-1:0] dir_z;

    modport source (
        output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
        input  ready
    );
    modport sink (
        input  valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
        output ready
    );
endinterface

// ===== hdl/rsi_hit_if.sv =====
`timescale 1ns / 1ps

interface rsi_hit_if;
    logic                         valid;
    logic                         ready;
    logic                         hit;
    logic [rsi_pkg::DIST_WIDTH-1:0]  distance;
    logic [rsi_pkg::COLOR_WIDTH-1:0] out_red;
    logic [rsi_pkg::COLOR_WIDTH-1:0] out_green;
    logic [rsi_pkg::COLOR_WIDTH-1:0] out_blue;

    modport source (
        output valid, hit, distance, out_red, out_green, out_blue,
        input  ready
    );
    modport sink (
        input  valid, hit, distance, out_red, out_green, out_blue,
        output ready
    );
endinterface

// ===== hdl/ray_sphere_intersection_unit.sv =====
`timescale 1ns / 1ps

// Ray against sphere test in a pipeline. One ray word is taken every cycle
// while the output is not stalled; the square root and the quotient, each
// one bit per stage, make up most of the depth. A stall at the output
// freezes the whole pipeline, and ready then stays low until the result is
// taken. Sphere center, radius and color come from the write port and are
// sampled as a ray passes; write them only while no ray is in flight.
module ray_sphere_intersection_unit #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    rsi_ray_if.sink                         i_ray,
    rsi_hit_if.source                       o_hit,
    input  logic                            i_cfg_we,
    input  logic [rsi_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [COORD_WIDTH-1:0]          i_cfg_data
);
    import rsi_pkg::*;

    localparam int W    = COORD_WIDTH;
    localparam int AW   = 2 * W + 2;          // a = dir.dir, signed container
    localparam int AUW  = 2 * W + 1;          // a as unsigned
    localparam int HCW  = 2 * W + 3;          // h and c
    localparam int DW   = 4 * W + 7;          // discriminant
    localparam int NW   = 4 * W + 2 + SQRT_SHIFT;
    localparam int RB   = NW / 2;
    localparam int NHW  = HCW + FRAC_BITS + 1;
    localparam int NNW  = NHW + 1;
    localparam int CMPW = AUW + DIST_WIDTH;
    localparam int SW   = 2 + AUW + NHW;

    // Configuration registers
    logic signed [W-1:0] r_center [3];
    logic [W-2:0]        r_radius;
    t_color              r_color [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_center[i] <= '0;
                r_color[i]  <= '0;
            end
            r_radius <= (W-1)'(1) << FRAC_BITS;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_CENTER_X:   r_center[0] <= i_cfg_data;
                CFG_CENTER_Y:   r_center[1] <= i_cfg_data;
                CFG_CENTER_Z:   r_center[2] <= i_cfg_data;
                CFG_RADIUS:     r_radius    <= i_cfg_data[W-2:0];
                CFG_COLOR_RED:  r_color[0]  <= i_cfg_data[COLOR_WIDTH-1:0];
                CFG_COLOR_GRN:  r_color[1]  <= i_cfg_data[COLOR_WIDTH-1:0];
                CFG_COLOR_BLUE: r_color[2]  <= i_cfg_data[COLOR_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    // Global advance: move when the output slot is free or being drained
    logic adv;
    logic r_out_vld;
    assign adv         = !r_out_vld || o_hit.ready;
    assign i_ray.ready = adv;

    // Valid bits of the pipeline stages
    logic r_v_a, r_v_b, r_v_c, r_v_d1, r_v_d2, r_v_g;
    logic sq_vld;
    logic r_dq_vld [0:DIST_WIDTH];

    // Stage A: offset from center
    logic signed [W:0]   r_oc  [3];
    logic signed [W-1:0] r_dir [3];
    logic signed [W-1:0] r_rad;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_oc[0]  <= (W+1)'(i_ray.origin_x) - (W+1)'(r_center[0]);
            r_oc[1]  <= (W+1)'(i_ray.origin_y) - (W+1)'(r_center[1]);
            r_oc[2]  <= (W+1)'(i_ray.origin_z) - (W+1)'(r_center[2]);
            r_dir[0] <= i_ray.dir_x;
            r_dir[1] <= i_ray.dir_y;
            r_dir[2] <= i_ray.dir_z;
            r_rad    <= $signed({1'b0, r_radius});
        end
    end

    // Stage B: per-axis products
    logic signed [2*W-1:0] r_dd [3];
    logic signed [2*W:0]   r_od [3];
    logic signed [2*W+1:0] r_oo [3];
    logic signed [2*W-1:0] r_rr;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                r_dd[i] <= r_dir[i] * r_dir[i];
                r_od[i] <= r_oc[i] * r_dir[i];
                r_oo[i] <= r_oc[i] * r_oc[i];
            end
            r_rr <= r_rad * r_rad;
        end
    end

    // Stage C: dot products
    logic signed [AW-1:0]  r_a;
    logic signed [HCW-1:0] r_h;
    logic signed [HCW-1:0] r_c;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a <= AW'(r_dd[0]) + AW'(r_dd[1]) + AW'(r_dd[2]);
            r_h <= HCW'(r_od[0]) + HCW'(r_od[1]) + HCW'(r_od[2]);
            r_c <= HCW'(r_oo[0]) + HCW'(r_oo[1]) + HCW'(r_oo[2]) - HCW'(r_rr);
        end
    end

    // Stages D and E: h*h and a*c, with the side data carried alongside
    logic signed [2*HCW-1:0]  mul_hh;
    logic signed [AW+HCW-1:0] mul_ac;

    rsi_mul #(.AW(HCW), .BW(HCW)) u_mul_hh (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_a   (r_h),
        .i_b   (r_h),
        .o_p   (mul_hh)
    );

    rsi_mul #(.AW(AW), .BW(HCW)) u_mul_ac (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_a   (r_a),
        .i_b   (r_c),
        .o_p   (mul_ac)
    );

    logic [AUW-1:0]        r_d1_a, r_d2_a;
    logic signed [HCW-1:0] r_d1_h, r_d2_h;
    logic                  r_d1_azero, r_d2_azero;
    logic                  r_d1_cneg, r_d2_cneg;
    logic                  r_d1_cpos, r_d2_cpos;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_d1_a     <= r_a[AUW-1:0];
            r_d1_h     <= r_h;
            r_d1_azero <= (r_a == '0);
            r_d1_cneg  <= r_c[HCW-1];
            r_d1_cpos  <= !r_c[HCW-1] && (r_c != '0);
            r_d2_a     <= r_d1_a;
            r_d2_h     <= r_d1_h;
            r_d2_azero <= r_d1_azero;
            r_d2_cneg  <= r_d1_cneg;
            r_d2_cpos  <= r_d1_cpos;
        end
    end

    // Discriminant, root choice and miss decision
    logic signed [DW-1:0]  v_d;
    logic signed [NHW-1:0] v_hx;
    logic signed [NHW-1:0] v_nh;
    logic                  v_hneg;
    logic                  v_miss;
    logic                  v_near;
    logic [NW-1:0]         v_rad;
    logic [SW-1:0]         v_side;

    always_comb begin
        v_d    = DW'(mul_hh) - DW'(mul_ac);
        v_hneg = r_d2_h[HCW-1];
        v_miss = r_d2_azero || v_d[DW-1] || (!v_hneg && !r_d2_cneg);
        v_near = v_hneg && r_d2_cpos;
        v_hx   = NHW'(r_d2_h);
        v_nh   = -(v_hx <<< FRAC_BITS);
        v_rad  = {v_d[NW-SQRT_SHIFT-1:0], {SQRT_SHIFT{1'b0}}};
        v_side = {v_miss, v_near, r_d2_a, v_nh};
    end

    // Square root pipeline
    logic [RB-1:0] sq_root;
    logic [SW-1:0] sq_side;

    rsi_sqrt #(.NW(NW), .SW(SW)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (r_v_d2),
        .i_rad   (v_rad),
        .i_side  (v_side),
        .o_valid (sq_vld),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    // Stage G: numerator of the chosen root
    logic signed [NNW-1:0] v_s;
    logic signed [NNW-1:0] v_nhx;
    logic signed [NNW-1:0] r_g_num;
    logic [AUW-1:0]        r_g_a;
    logic                  r_g_miss;

    always_comb begin
        v_s   = NNW'($signed({1'b0, sq_root}));
        v_nhx = NNW'($signed(sq_side[NHW-1:0]));
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_g_num  <= sq_side[SW-2] ? (v_nhx - v_s) : (v_nhx + v_s);
            r_g_a    <= sq_side[NHW +: AUW];
            r_g_miss <= sq_side[SW-1];
        end
    end

    // Quotient pipeline, one bit per stage, most significant first
    logic [CMPW-1:0]       r_dq_rem  [0:DIST_WIDTH];
    logic [DIST_WIDTH-1:0] r_dq_q    [0:DIST_WIDTH];
    logic [AUW-1:0]        r_dq_a    [0:DIST_WIDTH];
    logic                  r_dq_miss [0:DIST_WIDTH];
    logic                  r_dq_ovf  [0:DIST_WIDTH];

    logic [CMPW-1:0]       n_dq_rem  [0:DIST_WIDTH];
    logic [DIST_WIDTH-1:0] n_dq_q    [0:DIST_WIDTH];
    logic [CMPW-1:0]       v_dq_sub  [0:DIST_WIDTH-1];
    logic [CMPW-1:0]       v_num;

    always_comb begin
        v_num       = CMPW'(r_g_num[NNW-2:0]);
        n_dq_rem[0] = v_num;
        n_dq_q[0]   = '0;
        for (int j = 0; j < DIST_WIDTH; j++) begin
            v_dq_sub[j] = CMPW'(r_dq_a[j]) << (DIST_WIDTH - 1 - j);
            if (r_dq_rem[j] >= v_dq_sub[j]) begin
                n_dq_rem[j+1] = r_dq_rem[j] - v_dq_sub[j];
                n_dq_q[j+1]   = {r_dq_q[j][DIST_WIDTH-2:0], 1'b1};
            end else begin
                n_dq_rem[j+1] = r_dq_rem[j];
                n_dq_q[j+1]   = {r_dq_q[j][DIST_WIDTH-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_dq_a[0]    <= r_g_a;
            r_dq_miss[0] <= r_g_miss;
            r_dq_ovf[0]  <= v_num >= {r_g_a, {DIST_WIDTH{1'b0}}};
            for (int j = 0; j <= DIST_WIDTH; j++) begin
                r_dq_rem[j] <= n_dq_rem[j];
                r_dq_q[j]   <= n_dq_q[j];
            end
            for (int j = 0; j < DIST_WIDTH; j++) begin
                r_dq_a[j+1]    <= r_dq_a[j];
                r_dq_miss[j+1] <= r_dq_miss[j];
                r_dq_ovf[j+1]  <= r_dq_ovf[j];
            end
        end
    end

    // Output register
    logic   r_out_hit;
    t_dist  r_out_dist;
    t_color r_out_color [3];

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_hit  <= !r_dq_miss[DIST_WIDTH];
            r_out_dist <= r_dq_miss[DIST_WIDTH] ? '0 :
                          r_dq_ovf[DIST_WIDTH]  ? DIST_MAX : r_dq_q[DIST_WIDTH];
            for (int i = 0; i < 3; i++) begin
                r_out_color[i] <= r_dq_miss[DIST_WIDTH] ? '0 : r_color[i];
            end
        end
    end

    // Valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_a     <= 1'b0;
            r_v_b     <= 1'b0;
            r_v_c     <= 1'b0;
            r_v_d1    <= 1'b0;
            r_v_d2    <= 1'b0;
            r_v_g     <= 1'b0;
            r_out_vld <= 1'b0;
            for (int j = 0; j <= DIST_WIDTH; j++) r_dq_vld[j] <= 1'b0;
        end else if (adv) begin
            r_v_a       <= i_ray.valid;
            r_v_b       <= r_v_a;
            r_v_c       <= r_v_b;
            r_v_d1      <= r_v_c;
            r_v_d2      <= r_v_d1;
            r_v_g       <= sq_vld;
            r_dq_vld[0] <= r_v_g;
            for (int j = 0; j < DIST_WIDTH; j++) r_dq_vld[j+1] <= r_dq_vld[j];
            r_out_vld   <= r_dq_vld[DIST_WIDTH];
        end
    end

    assign o_hit.valid     = r_out_vld;
    assign o_hit.hit       = r_out_hit;
    assign o_hit.distance  = r_out_dist;
    assign o_hit.out_red   = r_out_color[0];
    assign o_hit.out_green = r_out_color[1];
    assign o_hit.out_blue  = r_out_color[2];

    // A chosen root is never behind the origin
    a_num_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v_g && !r_g_miss |-> !r_g_num[NNW-1])
        else $error("negative numerator on a hit");

    // A miss carries no distance and no color
    a_miss_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_hit.valid && !o_hit.hit |-> o_hit.distance == '0 &&
        o_hit.out_red == '0 && o_hit.out_green == '0 && o_hit.out_blue == '0)
        else $error("miss with payload");

    // Overflow on a hit saturates the distance
    a_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && r_dq_vld[DIST_WIDTH] && !r_dq_miss[DIST_WIDTH] && r_dq_ovf[DIST_WIDTH]
        |=> o_hit.distance == DIST_MAX)
        else $error("overflow not saturated");

    // A frozen pipeline keeps its front stage and stage G
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |=> $stable(r_v_a) && $stable(r_v_g))
        else $error("stage moved while stalled");
endmodule

// ===== hdl/rsi_mul.sv =====
`timescale 1ns / 1ps

// Two-stage signed multiplier built from four half-width partial products
module rsi_mul #(
    parameter int AW = 67,
    parameter int BW = 67
) (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic signed [AW-1:0]    i_a,
    input  logic signed [BW-1:0]    i_b,
    output logic signed [AW+BW-1:0] o_p
);
    localparam int LA = AW / 2;
    localparam int HA = AW - LA;
    localparam int LB = BW / 2;
    localparam int HB = BW - LB;
    localparam int PW = AW + BW;

    logic [AW-1:0]      v_mag_a;
    logic [BW-1:0]      v_mag_b;
    logic [LA+LB-1:0]   r_pp_ll;
    logic [LA+HB-1:0]   r_pp_lh;
    logic [HA+LB-1:0]   r_pp_hl;
    logic [HA+HB-1:0]   r_pp_hh;
    logic               r_neg;
    logic [PW-1:0]      v_sum;
    logic signed [PW-1:0] r_p;

    // Magnitudes of both operands, split into halves in stage one
    always_comb begin
        v_mag_a = i_a[AW-1] ? AW'(-i_a) : AW'(i_a);
        v_mag_b = i_b[BW-1] ? BW'(-i_b) : BW'(i_b);
    end

    // Stage one: partial products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pp_ll <= v_mag_a[LA-1:0] * v_mag_b[LB-1:0];
            r_pp_lh <= v_mag_a[LA-1:0] * v_mag_b[BW-1:LB];
            r_pp_hl <= v_mag_a[AW-1:LA] * v_mag_b[LB-1:0];
            r_pp_hh <= v_mag_a[AW-1:LA] * v_mag_b[BW-1:LB];
            r_neg   <= i_a[AW-1] ^ i_b[BW-1];
        end
    end

    // Stage two: combine and restore sign
    always_comb begin
        v_sum = PW'(r_pp_ll) + (PW'(r_pp_lh) << LB) + (PW'(r_pp_hl) << LA)
              + (PW'(r_pp_hh) << (LA + LB));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= r_neg ? $signed(-v_sum) : $signed(v_sum);
        end
    end

    assign o_p = r_p;
endmodule

// ===== hdl/rsi_sqrt.sv =====
`timescale 1ns / 1ps

// Integer square root, one result bit per pipeline stage, with a side word
module rsi_sqrt #(
    parameter int NW = 162,
    parameter int SW = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [NW-1:0]     i_rad,
    input  logic [SW-1:0]     i_side,
    output logic              o_valid,
    output logic [NW/2-1:0]   o_root,
    output logic [SW-1:0]     o_side
);
    localparam int RB = NW / 2;
    localparam int RW = RB + 2;

    logic [RW-1:0] r_rem  [0:RB];
    logic [RB-1:0] r_root [0:RB];
    logic [NW-1:0] r_rest [0:RB];
    logic [SW-1:0] r_side [0:RB];
    logic          r_vld  [0:RB];

    logic [RW-1:0] n_rem  [0:RB];
    logic [RB-1:0] n_root [0:RB];
    logic [NW-1:0] n_rest [0:RB];
    logic [RW-1:0] v_cur  [0:RB-1];
    logic [RW-1:0] v_trial[0:RB-1];

    // Try the next root bit in every stage
    always_comb begin
        n_rem[0]  = '0;
        n_root[0] = '0;
        n_rest[0] = i_rad;
        for (int k = 0; k < RB; k++) begin
            v_cur[k]   = {r_rem[k][RW-3:0], r_rest[k][NW-1 -: 2]};
            v_trial[k] = {r_root[k], 2'b01};
            if (v_cur[k] >= v_trial[k]) begin
                n_rem[k+1]  = v_cur[k] - v_trial[k];
                n_root[k+1] = {r_root[k][RB-2:0], 1'b1};
            end else begin
                n_rem[k+1]  = v_cur[k];
                n_root[k+1] = {r_root[k][RB-2:0], 1'b0};
            end
            n_rest[k+1] = r_rest[k] << 2;
        end
    end

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= RB; k++) r_vld[k] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_valid;
            for (int k = 0; k < RB; k++) r_vld[k+1] <= r_vld[k];
        end
    end

    // Advance payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_side;
            for (int k = 0; k <= RB; k++) begin
                r_rem[k]  <= n_rem[k];
                r_root[k] <= n_root[k];
                r_rest[k] <= n_rest[k];
            end
            for (int k = 0; k < RB; k++) r_side[k+1] <= r_side[k];
        end
    end

    assign o_valid = r_vld[RB];
    assign o_root  = r_root[RB];
    assign o_side  = r_side[RB];
endmodule
